### hw/rtl/gati_pkg.sv
// ----------------------------------------------------------------------------
// gati_pkg
// Shared constants, lane result types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gati_pkg;

    localparam int CORDIC_ITERATIONS = 24;
    localparam int ITER_N = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam int ITER_W = 6;

    localparam int ACC_W   = 36;
    localparam int VEC_W   = 32;
    localparam int DIFF_W  = 14;
    localparam int STEP_W  = 25;
    localparam int ANGLE_W = 32;
    localparam int HEAD_W  = 26;

    localparam logic signed [ACC_W-1:0] HALF_TURN_Q8  = 36'sd4608000000;
    localparam logic signed [ACC_W-1:0] ROUND_Q8      = 36'sd128;
    localparam logic signed [ACC_W-1:0] ANGLE_LIMIT   = 36'sd18000000;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 32'sd9000000;
    localparam logic [HEAD_W-1:0] HEADING_START       = 26'd18000000;
    localparam logic signed [27:0] FULL_TURN          = 28'sd36000000;
    localparam logic [19:0] RATE_K_Q24                = 20'd676005;

    localparam logic [2:0] REG_ACC_ZERO_X  = 3'd0;
    localparam logic [2:0] REG_ACC_ZERO_Y  = 3'd1;
    localparam logic [2:0] REG_ACC_ZERO_Z  = 3'd2;
    localparam logic [2:0] REG_GYRO_GAIN_X = 3'd3;
    localparam logic [2:0] REG_GYRO_GAIN_Y = 3'd4;
    localparam logic [2:0] REG_GYRO_GAIN_Z = 3'd5;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_GYRO  = 1'b1;

    typedef struct packed {
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } cordic_res_t;

    typedef struct packed {
        logic                     done;
        logic signed [STEP_W-1:0] step;
    } rate_res_t;

    // atan(2^-i) in degrees * 25600000
    function automatic logic [30:0] atan_entry(input logic [4:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd1152000000;
            5'd1:  v = 31'd680065310;
            5'd2:  v = 31'd359327833;
            5'd3:  v = 31'd182400419;
            5'd4:  v = 31'd91554160;
            5'd5:  v = 31'd45821712;
            5'd6:  v = 31'd22916447;
            5'd7:  v = 31'd11458923;
            5'd8:  v = 31'd5729549;
            5'd9:  v = 31'd2864785;
            5'd10: v = 31'd1432394;
            5'd11: v = 31'd716197;
            5'd12: v = 31'd358099;
            5'd13: v = 31'd179049;
            5'd14: v = 31'd89525;
            5'd15: v = 31'd44762;
            5'd16: v = 31'd22381;
            5'd17: v = 31'd11191;
            5'd18: v = 31'd5595;
            5'd19: v = 31'd2798;
            5'd20: v = 31'd1399;
            5'd21: v = 31'd699;
            5'd22: v = 31'd350;
            5'd23: v = 31'd175;
            5'd24: v = 31'd87;
            5'd25: v = 31'd44;
            5'd26: v = 31'd22;
            5'd27: v = 31'd11;
            5'd28: v = 31'd5;
            5'd29: v = 31'd3;
            5'd30: v = 31'd1;
            5'd31: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/gati_cordic.sv
// ----------------------------------------------------------------------------
// gati_cordic
// Iterative vectoring CORDIC lane, one rotation per cycle, gives atan2(y, x).
// ----------------------------------------------------------------------------
module gati_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gati_pkg::DIFF_W-1:0]  y_in,
    input  logic signed [gati_pkg::DIFF_W-1:0]  x_in,
    output gati_pkg::cordic_res_t               res
);
    import gati_pkg::*;

    logic signed [VEC_W-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ITER_W-1:0]        it_reg, it_next;
    logic                     busy_reg, busy_next, done_reg, done_next;
    logic                     zero_reg, zero_next;

    logic signed [DIFF_W-1:0] xs, ys;
    logic signed [VEC_W-1:0]  sx, sy;
    logic signed [ACC_W-1:0]  tab, rnd;

    assign sx  = x_reg >>> it_reg[4:0];
    assign sy  = y_reg >>> it_reg[4:0];
    assign tab = signed'({5'b0, atan_entry(it_reg[4:0])});
    assign xs  = x_in[DIFF_W-1] ? -x_in : x_in;
    assign ys  = x_in[DIFF_W-1] ? -y_in : y_in;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        zero_next = zero_reg;
        if (start)
        begin
            x_next    = {{(VEC_W-DIFF_W-16){xs[DIFF_W-1]}}, xs, 16'b0};
            y_next    = {{(VEC_W-DIFF_W-16){ys[DIFF_W-1]}}, ys, 16'b0};
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in[DIFF_W-1])
                acc_next = y_in[DIFF_W-1] ? -HALF_TURN_Q8 : HALF_TURN_Q8;
            else
                acc_next = '0;
            it_next   = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[VEC_W-1])
            begin
                x_next   = x_reg + sy;
                y_next   = y_reg - sx;
                acc_next = acc_reg + tab;
            end
            else
            begin
                x_next   = x_reg - sy;
                y_next   = y_reg + sx;
                acc_next = acc_reg - tab;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == ITER_W'(ITER_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        zero_reg <= zero_next;
    end

    // round to 1e-5 degree and clamp to half a turn
    assign rnd = (acc_reg + ROUND_Q8) >>> 8;

    always_comb
    begin
        res.done = done_reg;
        if (zero_reg)
            res.angle = '0;
        else if (rnd > ANGLE_LIMIT)
            res.angle = ANGLE_W'(ANGLE_LIMIT);
        else if (rnd < -ANGLE_LIMIT)
            res.angle = ANGLE_W'(-ANGLE_LIMIT);
        else
            res.angle = rnd[ANGLE_W-1:0];
    end

endmodule

### hw/rtl/gati_rate.sv
// ----------------------------------------------------------------------------
// gati_rate
// Gyro rate lane: rate * gain * K in two multiply stages, truncated toward zero.
// ----------------------------------------------------------------------------
module gati_rate (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic signed [12:0] rate,
    input  logic [15:0]       gain,
    output gati_pkg::rate_res_t res
);
    import gati_pkg::*;

    logic [12:0] mag;
    logic [28:0] prod_reg;
    logic        neg_reg;
    logic [48:0] full;
    logic [23:0] step_mag;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic        st1_reg, done_reg;

    assign mag      = rate[12] ? 13'(-rate) : 13'(rate);
    assign full     = prod_reg * RATE_K_Q24;
    assign step_mag = full[47:24];
    assign step_next = neg_reg ? -signed'({1'b0, step_mag}) : signed'({1'b0, step_mag});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st1_reg  <= start;
            if (start)
                done_reg <= 1'b0;
            else if (st1_reg)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= mag * gain;
            neg_reg  <= rate[12];
        end
        if (st1_reg)
            step_reg <= step_next;
    end

    assign res.done = done_reg;
    assign res.step = step_reg;

endmodule

### hw/rtl/gyro_accel_tilt_integrator.sv
// ----------------------------------------------------------------------------
// gyro_accel_tilt_integrator
// Attitude angles from an accelerometer tilt start and gyro rate integration.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | kind, accel_x/y/z, rate_x/y/z
//  out     | out_valid / out_stall  | angle_out_x, angle_out_y, angle_out_z
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  a start request runs the two iterative CORDIC lanes side by side and its
//  result is merged when both are done; a gyro request runs through the two
//  multiply stages of the rate lanes; the input frees once the result is merged
//  one request at a time; the next is taken while the last result waits
//  a stalled output holds the merge until the result slot frees
//  reset clears the angles to zero, offsets to 2048 and gains to zero
// ----------------------------------------------------------------------------
module gyro_accel_tilt_integrator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [11:0] accel_x,
    input  logic [11:0] accel_y,
    input  logic [11:0] accel_z,
    input  logic signed [12:0] rate_x,
    input  logic signed [12:0] rate_y,
    input  logic signed [12:0] rate_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] angle_out_x,
    output logic signed [31:0] angle_out_y,
    output logic [25:0] angle_out_z,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import gati_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t state_reg;
    logic   kind_reg, out_valid_reg;
    logic [11:0] zero_x_reg, zero_y_reg, zero_z_reg;
    logic [15:0] gain_x_reg, gain_y_reg, gain_z_reg;
    logic signed [ANGLE_W-1:0] tilt_x_reg, tilt_y_reg, tilt_x_next, tilt_y_next;
    logic [HEAD_W-1:0] head_reg, head_next;

    logic accept, finish, ready_all;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    cordic_res_t cx, cy;
    rate_res_t   rx, ry, rz;

    logic signed [32:0] sx, sy;
    logic signed [27:0] hz;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;

    assign dx = signed'({2'b0, accel_x}) - signed'({2'b0, zero_x_reg});
    assign dy = signed'({2'b0, accel_y}) - signed'({2'b0, zero_y_reg});
    assign dz = signed'({2'b0, accel_z}) - signed'({2'b0, zero_z_reg});

    gati_cordic u_cordic_x (.clk, .rst_n, .start(accept), .y_in(dz), .x_in(dx), .res(cx));
    gati_cordic u_cordic_y (.clk, .rst_n, .start(accept), .y_in(dy), .x_in(dz), .res(cy));

    gati_rate u_rate_x (.clk, .rst_n, .start(accept), .rate(rate_x), .gain(gain_x_reg), .res(rx));
    gati_rate u_rate_y (.clk, .rst_n, .start(accept), .rate(rate_y), .gain(gain_y_reg), .res(ry));
    gati_rate u_rate_z (.clk, .rst_n, .start(accept), .rate(rate_z), .gain(gain_z_reg), .res(rz));

    // merge of the lane results
    assign ready_all = (kind_reg == KIND_GYRO) ? (rx.done && ry.done && rz.done)
                                               : (cx.done && cy.done);
    assign finish = (state_reg == S_RUN) && ready_all && (!out_valid_reg || !out_stall);

    always_comb
    begin
        sx = 33'(tilt_x_reg) - 33'(rx.step);
        sy = 33'(tilt_y_reg) - 33'(ry.step);
        hz = signed'({2'b0, head_reg}) - 28'(rz.step);
        if (kind_reg == KIND_START)
        begin
            tilt_x_next = cx.angle;
            tilt_y_next = cy.angle + QUARTER_TURN;
            head_next   = HEADING_START;
        end
        else
        begin
            if (sx[32] != sx[31])
                tilt_x_next = sx[32] ? 32'sh80000000 : 32'sh7fffffff;
            else
                tilt_x_next = sx[31:0];
            if (sy[32] != sy[31])
                tilt_y_next = sy[32] ? 32'sh80000000 : 32'sh7fffffff;
            else
                tilt_y_next = sy[31:0];
            if (hz < 0)
                head_next = HEAD_W'(hz + FULL_TURN);
            else if (hz >= FULL_TURN)
                head_next = HEAD_W'(hz - FULL_TURN);
            else
                head_next = hz[HEAD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_START;
            out_valid_reg <= 1'b0;
            tilt_x_reg    <= '0;
            tilt_y_reg    <= '0;
            head_reg      <= '0;
            zero_x_reg    <= 12'd2048;
            zero_y_reg    <= 12'd2048;
            zero_z_reg    <= 12'd2048;
            gain_x_reg    <= '0;
            gain_y_reg    <= '0;
            gain_z_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ACC_ZERO_X:  zero_x_reg <= cfg_data[11:0];
                    REG_ACC_ZERO_Y:  zero_y_reg <= cfg_data[11:0];
                    REG_ACC_ZERO_Z:  zero_z_reg <= cfg_data[11:0];
                    REG_GYRO_GAIN_X: gain_x_reg <= cfg_data;
                    REG_GYRO_GAIN_Y: gain_y_reg <= cfg_data;
                    REG_GYRO_GAIN_Z: gain_z_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= kind;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (finish)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
            if (finish)
            begin
                tilt_x_reg    <= tilt_x_next;
                tilt_y_reg    <= tilt_y_next;
                head_reg      <= head_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign angle_out_x = tilt_x_reg;
    assign angle_out_y = tilt_y_reg;
    assign angle_out_z = head_reg;

endmodule

### hw/rtl/gati_checker.sv
// ----------------------------------------------------------------------------
// gati_checker
// Port-level checks for the tilt integrator, bound to the top level.
// ----------------------------------------------------------------------------
module gati_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [25:0] angle_out_z
);

    // result held under stall
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(angle_out_z))
        else $error("heading changed while stalled");

    // heading stays wrapped
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_out_z < 26'd36000000)
        else $error("heading out of range");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

endmodule

bind gyro_accel_tilt_integrator gati_checker u_gati_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .angle_out_z(angle_out_z)
);

### sim/tb_gyro_accel_tilt_integrator.sv
// ----------------------------------------------------------------------------
// tb_gyro_accel_tilt_integrator
// Drives start and gyro requests with random gaps and output stalls, predicts
// the three attitude angles per request and compares every result in order.
// ----------------------------------------------------------------------------
module tb_gyro_accel_tilt_integrator;
    import gati_pkg::*;

    typedef struct {
        logic              kind;
        logic [11:0]       ax;
        logic [11:0]       ay;
        logic [11:0]       az;
        logic signed [12:0] rx;
        logic signed [12:0] ry;
        logic signed [12:0] rz;
    } imu_req_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [25:0]        z;
    } angles_t;

    localparam int WATCHDOG_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = 1'b0;
    logic [11:0] accel_x = '0;
    logic [11:0] accel_y = '0;
    logic [11:0] accel_z = '0;
    logic signed [12:0] rate_x = '0;
    logic signed [12:0] rate_y = '0;
    logic signed [12:0] rate_z = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [31:0] angle_out_x;
    logic signed [31:0] angle_out_y;
    logic [25:0] angle_out_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    imu_req_t pending_reqs[$];
    angles_t  expected_angles[$];
    imu_req_t cur_req;
    int       mismatches = 0;
    int       max_in_gap = 8;
    int       max_out_stall = 8;
    int       in_gap_left = 0;
    int       stall_left = 0;
    int       quiet_cycles = 0;

    // mirrored registers and attitude state
    logic [11:0] m_zero_x, m_zero_y, m_zero_z;
    logic [15:0] m_gain_x, m_gain_y, m_gain_z;
    logic signed [31:0] m_tilt_x, m_tilt_y;
    logic [25:0] m_heading;

    longint atan_q8 [32] = '{
        1152000000, 680065310, 359327833, 182400419, 91554160, 45821712,
        22916447, 11458923, 5729549, 2864785, 1432394, 716197, 358099,
        179049, 89525, 44762, 22381, 11191, 5595, 2798, 1399, 699, 350,
        175, 87, 44, 22, 11, 5, 3, 1, 1
    };

    gyro_accel_tilt_integrator i_dut (.*);

    always #6 clk = ~clk;

    function automatic longint tilt_atan2(longint yv, longint xv);
        longint acc;
        longint nx;
        longint ny;
        longint q;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            acc = (yv >= 0) ? 64'sd4608000000 : -64'sd4608000000;
            xv = -xv;
            yv = -yv;
        end
        xv = xv * 65536;
        yv = yv * 65536;
        for (int i = 0; i < ITER_N; i++)
        begin
            if (yv >= 0)
            begin
                nx = xv + (yv >>> i);
                ny = yv - (xv >>> i);
                acc += atan_q8[i];
            end
            else
            begin
                nx = xv - (yv >>> i);
                ny = yv + (xv >>> i);
                acc -= atan_q8[i];
            end
            xv = nx;
            yv = ny;
        end
        q = (acc + 128) >>> 8;
        if (q > 18000000)
            q = 18000000;
        if (q < -18000000)
            q = -18000000;
        return q;
    endfunction

    // truncated toward zero
    function automatic longint rate_delta(logic signed [12:0] r, logic [15:0] g);
        longint p;
        p = longint'(r) * longint'(g) * 676005;
        return (p >= 0) ? (p >>> 24) : -((-p) >>> 24);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic angles_t attitude_update(imu_req_t r);
        angles_t a;
        longint h;
        if (r.kind == KIND_START)
        begin
            m_tilt_x = 32'(tilt_atan2(longint'(r.az) - longint'(m_zero_z),
                                      longint'(r.ax) - longint'(m_zero_x)));
            m_tilt_y = 32'(tilt_atan2(longint'(r.ay) - longint'(m_zero_y),
                                      longint'(r.az) - longint'(m_zero_z)) + 9000000);
            m_heading = 26'd18000000;
        end
        else
        begin
            m_tilt_x = clamp32(longint'(m_tilt_x) - rate_delta(r.rx, m_gain_x));
            m_tilt_y = clamp32(longint'(m_tilt_y) - rate_delta(r.ry, m_gain_y));
            h = (longint'(m_heading) - rate_delta(r.rz, m_gain_z)) % 36000000;
            if (h < 0)
                h += 36000000;
            m_heading = h[25:0];
        end
        a.x = m_tilt_x;
        a.y = m_tilt_y;
        a.z = m_heading;
        return a;
    endfunction

    function automatic imu_req_t rand_req(int start_pct);
        imu_req_t r;
        r.kind = ($urandom_range(99, 0) < start_pct) ? KIND_START : KIND_GYRO;
        r.ax = 12'($urandom);
        r.ay = 12'($urandom);
        r.az = 12'($urandom);
        r.rx = 13'($urandom);
        r.ry = 13'($urandom);
        r.rz = 13'($urandom);
        return r;
    endfunction

    function automatic imu_req_t make_req(logic k, int ax, int ay, int az,
                                          int rx, int ry, int rz);
        imu_req_t r;
        r.kind = k;
        r.ax = 12'(ax);
        r.ay = 12'(ay);
        r.az = 12'(az);
        r.rx = 13'(rx);
        r.ry = 13'(ry);
        r.rz = 13'(rz);
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_angles.push_back(attitude_update(cur_req));
            if (!in_valid || !in_stall)
            begin
                if (in_gap_left > 0)
                begin
                    in_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    kind    <= cur_req.kind;
                    accel_x <= cur_req.ax;
                    accel_y <= cur_req.ay;
                    accel_z <= cur_req.az;
                    rate_x  <= cur_req.rx;
                    rate_y  <= cur_req.ry;
                    rate_z  <= cur_req.rz;
                    in_valid <= 1'b1;
                    in_gap_left = $urandom_range(max_in_gap, 0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        angles_t e;
        if (!rst_n)
            out_stall <= 1'b1;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_angles.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    e = expected_angles.pop_front();
                    if (angle_out_x !== e.x)
                    begin
                        $error("angle_out_x expected %0d actual %0d", e.x, angle_out_x);
                        mismatches++;
                    end
                    if (angle_out_y !== e.y)
                    begin
                        $error("angle_out_y expected %0d actual %0d", e.y, angle_out_y);
                        mismatches++;
                    end
                    if (angle_out_z !== e.z)
                    begin
                        $error("angle_out_z expected %0d actual %0d", e.z, angle_out_z);
                        mismatches++;
                    end
                end
                stall_left = $urandom_range(max_out_stall, 0);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ACC_ZERO_X:  m_zero_x = data[11:0];
            REG_ACC_ZERO_Y:  m_zero_y = data[11:0];
            REG_ACC_ZERO_Z:  m_zero_z = data[11:0];
            REG_GYRO_GAIN_X: m_gain_x = data;
            REG_GYRO_GAIN_Y: m_gain_y = data;
            REG_GYRO_GAIN_Z: m_gain_z = data;
            default: ;
        endcase
    endtask

    task automatic set_regs(int zx, int zy, int zz, int gx, int gy, int gz);
        cfg_write(REG_ACC_ZERO_X, 16'(zx));
        cfg_write(REG_ACC_ZERO_Y, 16'(zy));
        cfg_write(REG_ACC_ZERO_Z, 16'(zz));
        cfg_write(REG_GYRO_GAIN_X, 16'(gx));
        cfg_write(REG_GYRO_GAIN_Y, 16'(gy));
        cfg_write(REG_GYRO_GAIN_Z, 16'(gz));
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !in_valid && expected_angles.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_reqs(int n, int start_pct);
        for (int i = 0; i < n; i++)
            pending_reqs.push_back(rand_req(start_pct));
    endtask

    initial
    begin
        m_zero_x = 12'd2048;
        m_zero_y = 12'd2048;
        m_zero_z = 12'd2048;
        m_gain_x = '0;
        m_gain_y = '0;
        m_gain_z = '0;
        m_tilt_x = '0;
        m_tilt_y = '0;
        m_heading = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: zero vector, accel extremes, gyro with zero gain
        pending_reqs.push_back(make_req(KIND_GYRO, 0, 0, 0, 4095, -4096, 1));
        pending_reqs.push_back(make_req(KIND_START, 2048, 2048, 2048, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_START, 0, 0, 0, 4095, 4095, 4095));
        pending_reqs.push_back(make_req(KIND_START, 4095, 4095, 4095, -4096, -4096, -4096));
        pending_reqs.push_back(make_req(KIND_START, 0, 4095, 2048, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_START, 4095, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_START, 2048, 0, 4095, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_GYRO, 4095, 4095, 4095, 4095, 4095, 4095));
        drain();

        // extreme gains, zero offsets
        set_regs(0, 0, 0, 65535, 65535, 65535);
        pending_reqs.push_back(make_req(KIND_START, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_START, 4095, 4095, 4095, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_GYRO, 0, 0, 0, 4095, -4096, 4095));
        pending_reqs.push_back(make_req(KIND_GYRO, 0, 0, 0, -4096, 4095, -4096));
        pending_reqs.push_back(make_req(KIND_GYRO, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(KIND_GYRO, 0, 0, 0, -1, 1, -1));
        // long same-sign runs drive X and Y into saturation both ways
        for (int i = 0; i < 220; i++)
            pending_reqs.push_back(make_req(KIND_GYRO, $urandom, $urandom, $urandom,
                                            4095, -4096, 4095));
        for (int i = 0; i < 440; i++)
            pending_reqs.push_back(make_req(KIND_GYRO, $urandom, $urandom, $urandom,
                                            -4096, 4095, -4096));
        drain();

        set_regs(4095, 4095, 4095, $urandom, $urandom, $urandom);
        random_reqs(130, 15);
        drain();

        // unknown indexes must leave the registers alone
        cfg_write(3'd6, 16'($urandom));
        cfg_write(3'd7, 16'($urandom));
        set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_reqs(130, 15);
        drain();

        max_in_gap = 0;
        max_out_stall = 0;
        set_regs($urandom, $urandom, $urandom, $urandom_range(65535, 60000),
                 $urandom, 0);
        random_reqs(130, 20);
        drain();

        max_in_gap = 8;
        max_out_stall = 8;
        set_regs(2048, 2048, 2048, $urandom, $urandom, $urandom);
        random_reqs(130, 10);
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
